/* hdl/dfsb_pkg.sv */
// Package for the dual queue shared buffer unit.
// Holds request codes, status codes and the result struct used by the
// controller and the top level. No dependencies.
`timescale 1ns / 1ps

package dfsb_pkg;

  localparam int DATA_W = 32;
  localparam int TOTAL_ENTRIES_DEF = 16;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic QSEL_ONE = 1'b0;
  localparam logic QSEL_TWO = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    logic    from_mem;
    status_t status;
    logic    first_empty;
    logic    first_full;
    logic    second_empty;
    logic    second_full;
  } res_t;

endpackage

/* hdl/dfsb_mem.sv */
// Entry store shared by both queues: one write port and one read port,
// with the read data registered. Depends on dfsb_pkg.
`timescale 1ns / 1ps

module dfsb_mem #(
  parameter int DEPTH  = dfsb_pkg::TOTAL_ENTRIES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [ADDR_W-1:0]                  wr_addr,
  input  logic signed [dfsb_pkg::DATA_W-1:0] wr_data,
  input  logic                               rd_en,
  input  logic [ADDR_W-1:0]                  rd_addr,
  output logic signed [dfsb_pkg::DATA_W-1:0] rd_data
);
  import dfsb_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/dfsb_ctrl.sv */
// Queue controller: head, tail and count registers of both queues, the
// full and empty decisions, and the store access for each item.
// Depends on dfsb_pkg.
`timescale 1ns / 1ps

module dfsb_ctrl #(
  parameter int TOTAL_ENTRIES = dfsb_pkg::TOTAL_ENTRIES_DEF,
  parameter int ADDR_W        = $clog2(TOTAL_ENTRIES)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic                               req_type,
  input  logic                               queue_sel,
  input  logic signed [dfsb_pkg::DATA_W-1:0] push_value,
  output logic                               wr_en,
  output logic [ADDR_W-1:0]                  wr_addr,
  output logic signed [dfsb_pkg::DATA_W-1:0] wr_data,
  output logic                               rd_en,
  output logic [ADDR_W-1:0]                  rd_addr,
  output dfsb_pkg::res_t                     res
);
  import dfsb_pkg::*;

  localparam int ONE_CAP  = TOTAL_ENTRIES / 2 + 1;
  localparam int TWO_BASE = TOTAL_ENTRIES / 2 + 1;
  localparam int TWO_CAP  = TOTAL_ENTRIES - TOTAL_ENTRIES / 2 - 1;
  localparam int C1_W     = $clog2(ONE_CAP + 1);
  localparam int C2_W     = $clog2(TWO_CAP + 1);

  logic [ADDR_W-1:0] head1_r, head1_nxt, tail1_r, tail1_nxt;
  logic [ADDR_W-1:0] head2_r, head2_nxt, tail2_r, tail2_nxt;
  logic [C1_W-1:0]   cnt1_r, cnt1_nxt;
  logic [C2_W-1:0]   cnt2_r, cnt2_nxt;
  res_t              res_r, res_nxt;
  logic              full_sel, empty_sel;

  function automatic logic [ADDR_W-1:0] adv1(input logic [ADDR_W-1:0] pos);
    if (pos == ADDR_W'(ONE_CAP - 1)) begin
      return '0;
    end
    return pos + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] adv2(input logic [ADDR_W-1:0] pos);
    if (pos == ADDR_W'(TOTAL_ENTRIES - 1)) begin
      return ADDR_W'(TWO_BASE);
    end
    return pos + ADDR_W'(1);
  endfunction

  assign full_sel  = (queue_sel == QSEL_TWO) ? (cnt2_r == C2_W'(TWO_CAP))
                                             : (cnt1_r == C1_W'(ONE_CAP));
  assign empty_sel = (queue_sel == QSEL_TWO) ? (cnt2_r == '0) : (cnt1_r == '0);

  always_comb begin
    head1_nxt = head1_r;
    tail1_nxt = tail1_r;
    head2_nxt = head2_r;
    tail2_nxt = tail2_r;
    cnt1_nxt  = cnt1_r;
    cnt2_nxt  = cnt2_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = (queue_sel == QSEL_TWO) ? tail2_r : tail1_r;
    rd_addr   = (queue_sel == QSEL_TWO) ? head2_r : head1_r;
    wr_data   = push_value;
    res_nxt   = '0;
    res_nxt.status = ST_OK;
    if (accept) begin
      res_nxt.valid = 1'b1;
      if (req_type == REQ_ENQ) begin
        if (full_sel) begin
          res_nxt.status = ST_FULL;
        end else begin
          wr_en = 1'b1;
          if (queue_sel == QSEL_TWO) begin
            tail2_nxt = adv2(tail2_r);
            cnt2_nxt  = cnt2_r + C2_W'(1);
          end else begin
            tail1_nxt = adv1(tail1_r);
            cnt1_nxt  = cnt1_r + C1_W'(1);
          end
        end
      end else begin
        if (empty_sel) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          rd_en            = 1'b1;
          res_nxt.from_mem = 1'b1;
          if (queue_sel == QSEL_TWO) begin
            head2_nxt = adv2(head2_r);
            cnt2_nxt  = cnt2_r - C2_W'(1);
          end else begin
            head1_nxt = adv1(head1_r);
            cnt1_nxt  = cnt1_r - C1_W'(1);
          end
        end
      end
    end
    res_nxt.first_empty  = (cnt1_nxt == '0);
    res_nxt.first_full   = (cnt1_nxt == C1_W'(ONE_CAP));
    res_nxt.second_empty = (cnt2_nxt == '0);
    res_nxt.second_full  = (cnt2_nxt == C2_W'(TWO_CAP));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head1_r <= '0;
      tail1_r <= '0;
      head2_r <= ADDR_W'(TWO_BASE);
      tail2_r <= ADDR_W'(TWO_BASE);
      cnt1_r  <= '0;
      cnt2_r  <= '0;
      res_r   <= '0;
    end else begin
      head1_r <= head1_nxt;
      tail1_r <= tail1_nxt;
      head2_r <= head2_nxt;
      tail2_r <= tail2_nxt;
      cnt1_r  <= cnt1_nxt;
      cnt2_r  <= cnt2_nxt;
      res_r   <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* hdl/dual_fifo_shared_buffer_unit.sv */
// Two circular queues sharing one entry store; one result per item.
// The result strobes in the cycle after the item is accepted.
// One item per cycle while busy is low; pointers and counts update at acceptance
// and the store read for a dequeue completes in the following cycle.
// Reset: synchronous active low; busy is high during reset, queues empty.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module dual_fifo_shared_buffer_unit #(
  parameter int TOTAL_ENTRIES = dfsb_pkg::TOTAL_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic                               in_queue_sel,
  input  logic signed [dfsb_pkg::DATA_W-1:0] in_push_value,
  output logic                               out_valid,
  output logic signed [dfsb_pkg::DATA_W-1:0] out_pop_value,
  output logic [1:0]                         out_status,
  output logic                               out_first_empty,
  output logic                               out_first_full,
  output logic                               out_second_empty,
  output logic                               out_second_full
);
  import dfsb_pkg::*;

  localparam int ADDR_W = $clog2(TOTAL_ENTRIES);

  logic                     busy_r;
  logic                     accept;
  logic                     wr_en, rd_en;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic signed [DATA_W-1:0] wr_data, rd_data;
  res_t                     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  dfsb_ctrl #(
    .TOTAL_ENTRIES(TOTAL_ENTRIES),
    .ADDR_W       (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .req_type  (in_req_type),
    .queue_sel (in_queue_sel),
    .push_value(in_push_value),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .res       (res)
  );

  dfsb_mem #(
    .DEPTH (TOTAL_ENTRIES),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_valid        = res.valid;
  assign out_status       = res.status;
  assign out_pop_value    = res.from_mem ? rd_data :
                            (res.status == ST_EMPTY) ? '1 : '0;
  assign out_first_empty  = res.first_empty;
  assign out_first_full   = res.first_full;
  assign out_second_empty = res.second_empty;
  assign out_second_full  = res.second_full;

  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("Result strobe without an accepted item.");

  a_empty_pop_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_pop_value == -32'sd1))
    else $error("Refused dequeue must return minus one.");

  a_full_pop_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_pop_value == '0 && !res.from_mem))
    else $error("Refused enqueue must return zero.");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_first_empty && out_first_full) &&
                  !(out_second_empty && out_second_full))
    else $error("A queue cannot be both empty and full.");

endmodule
